/* src/sfcp_pkg.sv */
// Shared types, codes and constant tables of the framed command parser.
package sfcp_pkg;

  typedef enum logic [1:0] {
    REQ_BYTE      = 2'd0,
    REQ_NAME_RD   = 2'd1,
    REQ_CLR_DIRTY = 2'd2,
    REQ_SET_AUTO  = 2'd3
  } sfcp_req_t;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHK     = 3'd5
  } sfcp_phase_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_NAME_RD = 2'd1,
    ST_SWEEP   = 2'd2,
    ST_ACK     = 2'd3
  } sfcp_state_t;

  localparam logic [7:0] SYNC1_BYTE     = 8'hAA;
  localparam logic [7:0] SYNC2_BYTE     = 8'h55;
  localparam logic [7:0] ACK_KIND       = 8'h81;
  localparam logic [7:0] KIND_PING      = 8'h01;
  localparam logic [7:0] KIND_STREAM_ON = 8'h10;
  localparam logic [7:0] KIND_STREAM_OFF = 8'h11;
  localparam logic [7:0] KIND_SET_NAME  = 8'h12;
  localparam logic [7:0] KIND_AUTOSTREAM = 8'h13;
  localparam logic [7:0] KIND_REC_START = 8'h14;
  localparam logic [7:0] KIND_REC_STOP  = 8'h15;

  // Index of the last acknowledgement byte.
  localparam logic [2:0] ACK_LAST = 3'd4;

  typedef struct packed {
    logic        streaming_on;
    logic        auto_stream_on;
    logic        settings_dirty;
    logic        record_start_pulse;
    logic        record_stop_pulse;
    logic        frame_accepted;
    logic [31:0] command_total;
    logic [7:0]  name_char;
    logic [7:0]  ack_out_byte;
    logic        ack_out_valid;
    logic        last_result;
  } sfcp_result_t;

  function automatic logic [7:0] sfcp_ack_byte(input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = SYNC1_BYTE;
      3'd1:    b = SYNC2_BYTE;
      3'd2:    b = ACK_KIND;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Factory device name, zero terminated.
  function automatic logic [7:0] sfcp_default_char(input logic [7:0] i);
    logic [7:0] c;
    unique case (i)
      8'd0:    c = 8'h48;
      8'd1:    c = 8'h50;
      8'd2:    c = 8'h49;
      8'd3:    c = 8'h35;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* src/sfcp_if.sv */
// Request and result channel interfaces of the framed command parser.
interface sfcp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic [4:0] name_index;

  modport source(output valid, req_type, data_byte, name_index, input ready);
  modport sink(input valid, req_type, data_byte, name_index, output ready);
endinterface

interface sfcp_out_if;
  logic        valid;
  logic        ready;
  logic        streaming_on;
  logic        auto_stream_on;
  logic        settings_dirty;
  logic        record_start_pulse;
  logic        record_stop_pulse;
  logic        frame_accepted;
  logic [31:0] command_total;
  logic [7:0]  name_char;
  logic [7:0]  ack_out_byte;
  logic        ack_out_valid;
  logic        last_result;

  modport source(output valid, streaming_on, auto_stream_on, settings_dirty,
                 record_start_pulse, record_stop_pulse, frame_accepted,
                 command_total, name_char, ack_out_byte, ack_out_valid,
                 last_result, input ready);
  modport sink(input valid, streaming_on, auto_stream_on, settings_dirty,
               record_start_pulse, record_stop_pulse, frame_accepted,
               command_total, name_char, ack_out_byte, ack_out_valid,
               last_result, output ready);
endinterface

/* src/sfcp_pay_mem.sv */
// Frame payload buffer: one write port, one registered read port.
module sfcp_pay_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* src/sfcp_name_mem.sv */
// Device name store with per-entry valid bits; unwritten entries read the factory name.
module sfcp_name_mem #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);
  import sfcp_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       mem_q_r;
  logic [7:0]       dflt_q_r;
  logic             vld_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q_r  <= mem[raddr];
    vld_q_r  <= vld_r[raddr];
    dflt_q_r <= sfcp_default_char(8'(raddr));
  end

  assign rdata = vld_q_r ? mem_q_r : dflt_q_r;
endmodule

/* src/sfcp_ctrl.sv */
// Frame parser, dispatch, copy/ack sequencer and result register.
module sfcp_ctrl #(
  parameter int MAX_PAYLOAD = 64,
  parameter int NAME_LEN    = 32,
  localparam int PAW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  localparam int NW  = $clog2(NAME_LEN),
  localparam int CW  = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_req_type,
  input  logic [7:0]             in_data_byte,
  input  logic [4:0]             in_name_index,
  output logic                   out_valid,
  input  logic                   out_ready,
  output sfcp_pkg::sfcp_result_t out_res,
  output logic                   pay_we,
  output logic [PAW-1:0]         pay_waddr,
  output logic [7:0]             pay_wdata,
  output logic [PAW-1:0]         pay_raddr,
  input  logic [7:0]             pay_rdata,
  output logic                   name_we,
  output logic [NW-1:0]          name_waddr,
  output logic [7:0]             name_wdata,
  output logic [NW-1:0]          name_raddr,
  input  logic [7:0]             name_rdata
);
  import sfcp_pkg::*;

  localparam logic [8:0] MAXP9 = 9'(MAX_PAYLOAD);
  localparam logic [8:0] NMAX9 = 9'(NAME_LEN - 1);
  localparam int TERM_RST = (NAME_LEN - 1 < 4) ? NAME_LEN - 1 : 4;
  localparam logic [NW-1:0] SW_LAST = NW'(NAME_LEN - 1);

  sfcp_state_t  state_r, state_nxt;
  sfcp_phase_t  phase_r, phase_nxt;
  sfcp_req_t    req;
  logic [7:0]   kind_r, kind_nxt;
  logic [7:0]   flen_r, flen_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]   xor_r, xor_nxt;
  logic [7:0]   first_r, first_nxt;
  logic         stream_r, stream_nxt;
  logic         auto_r, auto_nxt;
  logic         dirty_r, dirty_nxt;
  logic [31:0]  total_r, total_nxt;
  logic [NW-1:0] term_r, term_nxt;
  logic [NW-1:0] sw_idx_r, sw_idx_nxt;
  logic         copy_r, copy_nxt;
  logic [2:0]   ack_idx_r, ack_idx_nxt;
  logic         name_ok_r, name_ok_nxt;
  logic         out_valid_r, out_valid_nxt;
  sfcp_result_t res_r, res_nxt;

  logic         accept, is_byte, out_free;
  logic         frame_ok, ping, rec_start, rec_stop, set_name;
  logic [8:0]   sw_next9;
  logic         keep;

  assign req      = sfcp_req_t'(in_req_type);
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign is_byte  = accept && (req == REQ_BYTE);
  assign sw_next9 = 9'(sw_idx_r) + 9'd1;

  // Byte parser and frame dispatch.
  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    flen_nxt  = flen_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    first_nxt = first_r;
    frame_ok  = 1'b0;
    pay_we    = 1'b0;
    if (is_byte) begin
      unique case (phase_r)
        PH_SYNC2: phase_nxt = (in_data_byte == SYNC2_BYTE) ? PH_TYPE : PH_SYNC1;
        PH_TYPE: begin
          kind_nxt  = in_data_byte;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          flen_nxt = in_data_byte;
          if (9'(in_data_byte) > MAXP9) begin
            phase_nxt = PH_SYNC1;
          end else begin
            cnt_nxt   = '0;
            xor_nxt   = 8'h00;
            phase_nxt = (in_data_byte == 8'h00) ? PH_CHK : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (9'(cnt_r) < MAXP9) begin
            pay_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            xor_nxt = xor_r ^ in_data_byte;
            if (cnt_r == '0) begin
              first_nxt = in_data_byte;
            end
          end
          if (9'(cnt_nxt) >= 9'(flen_r)) begin
            phase_nxt = PH_CHK;
          end
        end
        PH_CHK: begin
          frame_ok  = (in_data_byte == xor_r);
          phase_nxt = PH_SYNC1;
        end
        default: phase_nxt = (in_data_byte == SYNC1_BYTE) ? PH_SYNC2 : PH_SYNC1;
      endcase
    end
  end

  assign pay_waddr = PAW'(cnt_r);
  assign pay_wdata = in_data_byte;

  // Flags, count and dispatch effects.
  always_comb begin
    stream_nxt = stream_r;
    auto_nxt   = auto_r;
    dirty_nxt  = dirty_r;
    total_nxt  = total_r;
    ping       = 1'b0;
    rec_start  = 1'b0;
    rec_stop   = 1'b0;
    set_name   = 1'b0;
    if (frame_ok) begin
      total_nxt = total_r + 32'd1;
      unique case (kind_r)
        KIND_PING:       ping = 1'b1;
        KIND_STREAM_ON:  stream_nxt = 1'b1;
        KIND_STREAM_OFF: stream_nxt = 1'b0;
        KIND_SET_NAME: begin
          set_name  = 1'b1;
          dirty_nxt = 1'b1;
        end
        KIND_AUTOSTREAM: begin
          if (flen_r != 8'h00) begin
            auto_nxt  = (first_r != 8'h00);
            dirty_nxt = 1'b1;
          end
        end
        KIND_REC_START:  rec_start = 1'b1;
        KIND_REC_STOP:   rec_stop = 1'b1;
        default: ;
      endcase
    end
    if (accept && req == REQ_CLR_DIRTY) begin
      dirty_nxt = 1'b0;
    end
    if (accept && req == REQ_SET_AUTO) begin
      auto_nxt = (in_data_byte != 8'h00);
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && req == REQ_NAME_RD) begin
          state_nxt = ST_NAME_RD;
        end else if (set_name) begin
          state_nxt = ST_SWEEP;
        end else if (ping) begin
          state_nxt = ST_ACK;
        end
      end
      ST_NAME_RD: state_nxt = ST_IDLE;
      ST_SWEEP: begin
        if (sw_idx_r == SW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ACK: begin
        if (out_free && ack_idx_r == ACK_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer datapath: name copy sweep, ack stepping, result register.
  always_comb begin
    term_nxt      = term_r;
    sw_idx_nxt    = sw_idx_r;
    copy_nxt      = copy_r;
    ack_idx_nxt   = ack_idx_r;
    name_ok_nxt   = name_ok_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    name_we       = 1'b0;
    name_waddr    = sw_idx_r;
    name_wdata    = 8'h00;
    pay_raddr     = '0;
    keep          = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          name_ok_nxt = 9'(in_name_index) < 9'(term_r);
          sw_idx_nxt  = '0;
          ack_idx_nxt = '0;
          if (set_name) begin
            copy_nxt = 1'b1;
            term_nxt = '0;
          end
          if (req != REQ_NAME_RD) begin
            out_valid_nxt              = 1'b1;
            res_nxt.streaming_on       = stream_nxt;
            res_nxt.auto_stream_on     = auto_nxt;
            res_nxt.settings_dirty     = dirty_nxt;
            res_nxt.record_start_pulse = rec_start;
            res_nxt.record_stop_pulse  = rec_stop;
            res_nxt.frame_accepted     = frame_ok;
            res_nxt.command_total      = total_nxt;
            res_nxt.name_char          = 8'h00;
            res_nxt.ack_out_byte       = 8'h00;
            res_nxt.ack_out_valid      = 1'b0;
            res_nxt.last_result        = !ping;
          end
        end
      end
      ST_NAME_RD: begin
        out_valid_nxt              = 1'b1;
        res_nxt.streaming_on       = stream_r;
        res_nxt.auto_stream_on     = auto_r;
        res_nxt.settings_dirty     = dirty_r;
        res_nxt.record_start_pulse = 1'b0;
        res_nxt.record_stop_pulse  = 1'b0;
        res_nxt.frame_accepted     = 1'b0;
        res_nxt.command_total      = total_r;
        res_nxt.name_char          = name_ok_r ? name_rdata : 8'h00;
        res_nxt.ack_out_byte       = 8'h00;
        res_nxt.ack_out_valid      = 1'b0;
        res_nxt.last_result        = 1'b1;
      end
      ST_SWEEP: begin
        // Copy until the length, the name limit or a zero byte; zero the rest.
        keep = copy_r && (9'(sw_idx_r) < 9'(flen_r)) && (9'(sw_idx_r) < NMAX9)
               && (pay_rdata != 8'h00);
        name_we    = 1'b1;
        name_wdata = keep ? pay_rdata : 8'h00;
        copy_nxt   = keep;
        if (keep) begin
          term_nxt = sw_idx_r + 1'b1;
        end
        sw_idx_nxt = sw_idx_r + 1'b1;
        if (sw_next9 < MAXP9) begin
          pay_raddr = PAW'(sw_next9);
        end
      end
      ST_ACK: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          res_nxt.ack_out_byte  = sfcp_ack_byte(ack_idx_r);
          res_nxt.ack_out_valid = 1'b1;
          res_nxt.last_result   = (ack_idx_r == ACK_LAST);
          ack_idx_nxt           = ack_idx_r + 3'd1;
        end
      end
      default: ;
    endcase
  end

  assign name_raddr = NW'(9'(in_name_index));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SYNC1;
      stream_r    <= 1'b1;
      auto_r      <= 1'b1;
      dirty_r     <= 1'b0;
      total_r     <= 32'd0;
      term_r      <= NW'(TERM_RST);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      stream_r    <= stream_nxt;
      auto_r      <= auto_nxt;
      dirty_r     <= dirty_nxt;
      total_r     <= total_nxt;
      term_r      <= term_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    flen_r    <= flen_nxt;
    cnt_r     <= cnt_nxt;
    xor_r     <= xor_nxt;
    first_r   <= first_nxt;
    sw_idx_r  <= sw_idx_nxt;
    copy_r    <= copy_nxt;
    ack_idx_r <= ack_idx_nxt;
    name_ok_r <= name_ok_nxt;
    res_r     <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;
endmodule

/* src/sync_framed_command_parser.sv */
// Top level of the synchronized, length-framed host command parser.
//
//   channel   dir  handshake          payload
//   in_req    in   valid / ready      req_type, data_byte, name_index
//   out_res   out  valid / ready      flags, pulses, command_total, name_char, ack
//
// Host byte, clear-dirty and set-autostream requests: once accepted, the status result
// sits in the output register from the next cycle.
// Name read: the registered read of the name store feeds the result register.
// Set-name frame end: a copy sweep over all NAME_LEN name entries, one name entry a cycle.
// Ping frame end: six results, one a cycle while out_res.ready stays high.
// Reset clears the name store valid bits at once; no clearing pass.
module sync_framed_command_parser #(
  parameter int MAX_PAYLOAD = 64,
  parameter int NAME_LEN    = 32
) (
  input logic     clk,
  input logic     rst_n,
  sfcp_in_if.sink     in_req,
  sfcp_out_if.source  out_res
);
  import sfcp_pkg::*;

  localparam int PAW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int NW  = $clog2(NAME_LEN);

  sfcp_result_t   res;
  logic           pay_we;
  logic [PAW-1:0] pay_waddr, pay_raddr;
  logic [7:0]     pay_wdata, pay_rdata;
  logic           name_we;
  logic [NW-1:0]  name_waddr, name_raddr;
  logic [7:0]     name_wdata, name_rdata;

  sfcp_ctrl #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .NAME_LEN   (NAME_LEN)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_req.valid),
    .in_ready     (in_req.ready),
    .in_req_type  (in_req.req_type),
    .in_data_byte (in_req.data_byte),
    .in_name_index(in_req.name_index),
    .out_valid    (out_res.valid),
    .out_ready    (out_res.ready),
    .out_res      (res),
    .pay_we       (pay_we),
    .pay_waddr    (pay_waddr),
    .pay_wdata    (pay_wdata),
    .pay_raddr    (pay_raddr),
    .pay_rdata    (pay_rdata),
    .name_we      (name_we),
    .name_waddr   (name_waddr),
    .name_wdata   (name_wdata),
    .name_raddr   (name_raddr),
    .name_rdata   (name_rdata)
  );

  sfcp_pay_mem #(.DEPTH(MAX_PAYLOAD)) u_pay_mem (
    .clk  (clk),
    .we   (pay_we),
    .waddr(pay_waddr),
    .wdata(pay_wdata),
    .raddr(pay_raddr),
    .rdata(pay_rdata)
  );

  sfcp_name_mem #(.DEPTH(NAME_LEN)) u_name_mem (
    .clk  (clk),
    .rst_n(rst_n),
    .we   (name_we),
    .waddr(name_waddr),
    .wdata(name_wdata),
    .raddr(name_raddr),
    .rdata(name_rdata)
  );

  assign out_res.streaming_on       = res.streaming_on;
  assign out_res.auto_stream_on     = res.auto_stream_on;
  assign out_res.settings_dirty     = res.settings_dirty;
  assign out_res.record_start_pulse = res.record_start_pulse;
  assign out_res.record_stop_pulse  = res.record_stop_pulse;
  assign out_res.frame_accepted     = res.frame_accepted;
  assign out_res.command_total      = res.command_total;
  assign out_res.name_char          = res.name_char;
  assign out_res.ack_out_byte       = res.ack_out_byte;
  assign out_res.ack_out_valid      = res.ack_out_valid;
  assign out_res.last_result        = res.last_result;

`ifndef SYNTHESIS
  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.ready |-> !in_req.ready)
    else $error("request taken while a result is stalled");

  a_ack_from_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.ack_out_valid |-> out_res.frame_accepted)
    else $error("ack byte without an accepted frame");

  a_one_rec_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !(out_res.record_start_pulse && out_res.record_stop_pulse))
    else $error("start and stop pulse together");

  a_hold_until_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && !out_res.last_result |-> !in_req.ready)
    else $error("new request taken before the last result of a step");
`endif
endmodule
